### design/multilevel_priority_ready_queue_assert.svh
// Assertion macros for the multilevel priority ready queue
`ifndef MULTILEVEL_PRIORITY_READY_QUEUE_ASSERT_SVH
`define MULTILEVEL_PRIORITY_READY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define MPRQ_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MPRQ_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPRQ_ASSERT_IMPL(label, clk, rst, prop, msg)
`define MPRQ_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### design/mprq_pkg.sv
// ----------------------------------------------------------------------------
// mprq_pkg
// Types and codes shared by the ready queue controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mprq_pkg;
  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] task_id;
    logic [5:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] chosen_task;
    logic [5:0] chosen_level;
    logic [6:0] queued_count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture input item
    logic search;  // step the level search
    logic lookup;  // read per-task and per-level state
    logic commit;  // rewrite links and form result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic search_done;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_COMMIT = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;
endpackage

### design/mprq_ctrl.sv
// ----------------------------------------------------------------------------
// mprq_ctrl
// Sequencer: load, level search, state lookup, commit, then offer the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mprq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output mprq_pkg::dp_cmd_t   cmd,
  input  mprq_pkg::dp_status_t stat
);
  import mprq_pkg::*;

  state_t state, state_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // Issue datapath commands
  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.search = (state == S_SEARCH);
    cmd.lookup = (state == S_LOOKUP);
    cmd.commit = (state == S_COMMIT);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SEARCH;
      S_SEARCH: if (stat.search_done) state_next = S_LOOKUP;
      S_LOOKUP: state_next = S_COMMIT;
      S_COMMIT: state_next = S_OUT;
      S_OUT:    if (!out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

### design/mprq_dp.sv
// ----------------------------------------------------------------------------
// mprq_dp
// Link memories, level bitmap, group search and list update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mprq_dp #(
  parameter int LEVELS = 64,
  parameter int TASKS  = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mprq_pkg::in_item_t   in_item,
  input  mprq_pkg::dp_cmd_t    cmd,
  output mprq_pkg::dp_status_t stat,
  output mprq_pkg::out_item_t  out_item
);
  import mprq_pkg::*;

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int KW = $clog2(TASKS + 1);       // link width, holds null
  localparam int CW = $clog2(TASKS + 1);
  localparam int GS = 16;                       // levels scanned per cycle
  localparam int NG = (LEVELS + GS - 1) / GS;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam logic [KW-1:0] NIL = KW'(TASKS);

  // State
  logic [LEVELS-1:0] level_nonempty;
  logic [TASKS-1:0]  task_queued;
  logic [CW-1:0]     task_count;
  logic [TW-1:0] level_head [LEVELS];
  logic [TW-1:0] level_tail [LEVELS];
  logic [KW-1:0] next_link  [TASKS];
  logic [KW-1:0] prev_link  [TASKS];
  logic [LW-1:0] task_level [TASKS];

  // Captured item and working registers
  in_item_t   item;
  logic [GW-1:0] grp;
  logic       found;
  logic [LW-1:0] sel_level;
  logic       id_ok, lv_ok;
  logic [TW-1:0] tid;
  logic [LW-1:0] plv;
  // Lookup results
  logic [TW-1:0] r_head, r_tail;
  logic [KW-1:0] r_prev, r_next;
  logic [LW-1:0] r_tlevel;
  logic          r_ne, r_queued;

  assign id_ok = ({26'd0, item.task_id} < 32'(TASKS));
  assign lv_ok = ({26'd0, item.priority_req} < 32'(LEVELS));
  assign tid   = TW'(item.task_id);
  assign plv   = LW'(item.priority_req);

  // Scan one group of levels, highest first
  logic            g_hit;
  logic [LW-1:0]   g_level;
  always_comb begin
    int base;
    g_hit   = 1'b0;
    g_level = '0;
    base    = int'(grp) * GS;
    for (int i = 0; i < GS; i++) begin
      if (!g_hit && (base + GS - 1 - i) < LEVELS) begin
        if (level_nonempty[base + GS - 1 - i]) begin
          g_hit   = 1'b1;
          g_level = LW'(base + GS - 1 - i);
        end
      end
    end
  end
  assign stat.search_done = cmd.search &&
    (item.command != CMD_POP || g_hit || found || grp == '0);

  // Capture the item, then step the search and read the head of the hit level
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item  <= in_item;
      grp   <= GW'(NG - 1);
      found <= 1'b0;
    end else if (cmd.search && !found) begin
      if (g_hit) begin
        found     <= 1'b1;
        sel_level <= g_level;
        r_head    <= level_head[g_level];
      end else if (grp != '0) begin
        grp <= grp - GW'(1);
      end
    end
  end

  // Lookup: the task concerned, its neighbours and its level
  logic [TW-1:0] op_task;
  logic [LW-1:0] op_level;
  logic [TW-1:0] lk_task;
  assign lk_task = (item.command == CMD_POP) ? r_head : tid;
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      r_queued <= task_queued[tid];
      r_tlevel <= task_level[tid];
      r_prev   <= prev_link[lk_task];
      r_next   <= next_link[lk_task];
      r_tail   <= level_tail[plv];
      r_ne     <= level_nonempty[plv];
    end
  end

  // Commit stage: decide, then update state
  logic do_push, do_unlink;
  always_comb begin
    do_push   = (item.command == CMD_PUSH) && id_ok && lv_ok && !task_queued[tid];
    do_unlink = 1'b0;
    op_task   = tid;
    op_level  = r_tlevel;
    if (item.command == CMD_POP && found) begin
      do_unlink = 1'b1;
      op_task   = r_head;
      op_level  = sel_level;
    end else if (item.command == CMD_REMOVE && id_ok && r_queued) begin
      do_unlink = 1'b1;
      op_level  = r_tlevel;
    end
  end

  logic [KW-1:0] u_prev, u_next;
  assign u_prev = r_prev;
  assign u_next = r_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_nonempty <= '0;
      task_queued    <= '0;
      task_count     <= '0;
    end else if (cmd.commit) begin
      if (do_push) begin
        level_nonempty[plv] <= 1'b1;
        task_queued[tid]    <= 1'b1;
        task_count          <= task_count + CW'(1);
      end else if (do_unlink) begin
        if (u_prev == NIL && u_next == NIL) level_nonempty[op_level] <= 1'b0;
        task_queued[op_task] <= 1'b0;
        task_count           <= task_count - CW'(1);
      end
    end
  end

  // Link and head/tail memories
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (do_push) begin
        next_link[tid]  <= NIL;
        task_level[tid] <= plv;
        level_tail[plv] <= tid;
        if (r_ne) begin
          prev_link[tid] <= KW'(r_tail);
          next_link[r_tail] <= KW'(tid);
        end else begin
          prev_link[tid]  <= NIL;
          level_head[plv] <= tid;
        end
      end else if (do_unlink) begin
        if (u_prev == NIL) level_head[op_level] <= TW'(u_next);
        else next_link[TW'(u_prev)] <= u_next;
        if (u_next == NIL) level_tail[op_level] <= TW'(u_prev);
        else prev_link[TW'(u_next)] <= u_prev;
      end
    end
  end

  // Result register
  logic [CW-1:0] count_after;
  assign count_after = do_push ? task_count + CW'(1) :
                       do_unlink ? task_count - CW'(1) : task_count;
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item.queued_count <= 7'(count_after);
      if (do_push) begin
        out_item.status       <= ST_DONE;
        out_item.chosen_task  <= item.task_id;
        out_item.chosen_level <= item.priority_req;
      end else if (do_unlink) begin
        out_item.status       <= ST_DONE;
        out_item.chosen_task  <= 6'(op_task);
        out_item.chosen_level <= 6'(op_level);
      end else begin
        out_item.status       <= (item.command == CMD_POP) ? ST_EMPTY : ST_BAD;
        out_item.chosen_task  <= '0;
        out_item.chosen_level <= '0;
      end
    end
  end
endmodule

### design/multilevel_priority_ready_queue.sv
// A sequential ready queue: one command is taken at a time and answered with
// one result. Each command passes through level search, state lookup and
// commit before its result is offered; pop scans the level bitmap in groups of
// sixteen levels from the top down to the highest nonempty level (up to four
// groups at 64 levels). The next command is taken once the result transfers.
// ----------------------------------------------------------------------------
// multilevel_priority_ready_queue
// Per-level FIFO ready queue with push, pop-highest and remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multilevel_priority_ready_queue_assert.svh"
module multilevel_priority_ready_queue #(
  parameter int LEVELS = 64,
  parameter int TASKS  = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mprq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mprq_pkg::out_item_t out_data
);
  import mprq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  mprq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  mprq_dp #(.LEVELS(LEVELS), .TASKS(TASKS)) u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .stat, .out_item(out_data)
  );

  `MPRQ_ASSERT_IMPL(a_one_cmd, clk, rst, $onehot0(cmd), "overlapping commands")
  `MPRQ_ASSERT_IMPL(a_busy, clk, rst, out_valid |-> in_stall, "input open with result")
  `MPRQ_ASSERT_IMPL(a_commit_out, clk, rst, cmd.commit |=> out_valid, "no result after commit")
  `MPRQ_ASSERT_RST(a_rst_idle, clk, $past(rst) |-> !out_valid, "result after reset")
endmodule
